// File: src/artt_pkg.sv
// Shared widths, codes, payload types and state encoding for the ms tick timer.
package artt_pkg;

   localparam int TIMER_W     = 64;
   localparam int TICKS_W     = 20;
   localparam int RATE_W      = 21;
   localparam int OP_W        = 3;
   localparam int CODE_W      = 3;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 64;
   localparam int DIVIDEND_W  = TIMER_W + 1;
   localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);
   localparam int ADJ_W       = RATE_W + 2;

   localparam int COUNTER_WIDTH_DEF = 64;

   localparam logic [TICKS_W-1:0]    TICKS_PER_MS_RST = TICKS_W'(24000);
   localparam logic [CSR_DATA_W-1:0] COUNTER_MAX_RST  = {CSR_DATA_W{1'b1}};

   // floor(x/25) = (x * recip) >> shift, exact over the operand width used
   localparam logic [17:0] COARSE_RECIP = 18'd167773;  // x < 2^17, shift 22
   localparam logic [16:0] MEDIUM_RECIP = 17'd67109;   // x/125, x < 2^16, shift 23
   localparam logic [18:0] LIMIT_RECIP  = 19'd335545;  // x < 2^18, shift 23

   localparam logic [OP_W-1:0] OP_POWER_ON    = 3'd0;
   localparam logic [OP_W-1:0] OP_TIMER_READ  = 3'd1;
   localparam logic [OP_W-1:0] OP_ADJUST      = 3'd2;
   localparam logic [OP_W-1:0] OP_READ_RESET  = 3'd3;
   localparam logic [OP_W-1:0] OP_READ_STOP   = 3'd4;

   localparam logic [CODE_W-1:0] ADJ_COARSE_INC = 3'd0;
   localparam logic [CODE_W-1:0] ADJ_COARSE_DEC = 3'd1;
   localparam logic [CODE_W-1:0] ADJ_MEDIUM_INC = 3'd2;
   localparam logic [CODE_W-1:0] ADJ_MEDIUM_DEC = 3'd3;
   localparam logic [CODE_W-1:0] ADJ_FINE_INC   = 3'd4;
   localparam logic [CODE_W-1:0] ADJ_FINE_DEC   = 3'd5;

   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_MS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNTER_MAX  = 1'd1;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [TIMER_W-1:0] counter_now;
      logic [CODE_W-1:0]  adjust_code;
   } req_type;

   typedef struct packed {
      logic [TIMER_W-1:0] timer_ms;
      logic               flag;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DELTA,
      ST_ADD_LEFT,
      ST_DIV,
      ST_UPDATE,
      ST_RESULT
   } state_type;

endpackage

// File: src/adjustable_rate_ms_tick_timer.sv
// A timer read of a seeded timer runs EXEC, DELTA, ADD_LEFT, DIV, UPDATE and RESULT; a seed by
// power-on op or first read skips DELTA and ADD_LEFT, and adjust and flag reads go EXEC to RESULT.
// The 65-step bit-serial restoring divider (one quotient bit per cycle) sets the read time.
// One item at a time: the next request beat is taken once the result sits in the output
// register.
// Synchronous active-high reset: timer, leftover, rate and flags clear, ticks_per_ms
// returns to 24000 and counter_max to all ones.
module adjustable_rate_ms_tick_timer #(
   parameter int COUNTER_WIDTH = artt_pkg::COUNTER_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  artt_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output artt_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [artt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [artt_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int TW = artt_pkg::TIMER_W;
   localparam int RW = artt_pkg::RATE_W;
   localparam int NW = artt_pkg::TICKS_W;
   localparam int AW = artt_pkg::ADJ_W;
   localparam int DW = artt_pkg::DIVIDEND_W;
   localparam int CW = artt_pkg::DIV_CNT_W;
   localparam logic [TW-1:0] CNT_MASK = {TW{1'b1}} >> (TW - COUNTER_WIDTH);

   artt_pkg::state_type state_ff, state_in;

   // configuration
   logic [NW-1:0] ticks_per_ms_ff;
   logic [TW-1:0] counter_max_ff;

   // derived step sizes
   logic [12:0] coarse_ff;
   logic [9:0]  medium_ff;
   logic [13:0] pct_ff;

   // timer state
   logic [TW-1:0] last_counter_ff;
   logic          primed_ff;
   logic [TW-1:0] timer_value_ff;
   logic [RW-1:0] leftover_ff;
   logic [RW-1:0] rate_ff;
   logic          was_reset_ff;
   logic          was_stopped_ff;

   // item and divider
   artt_pkg::req_type item_ff;
   logic [DW-1:0] div_ff;
   logic [RW-1:0] rem_ff;
   logic [RW-1:0] divisor_ff;
   logic [CW-1:0] div_cnt_ff;
   logic          seed_ff;
   logic          wrap_ff;
   logic          res_flag_ff;

   // output register
   logic              rsp_valid_ff;
   artt_pkg::rsp_type rsp_data_ff;

   logic          req_accept;
   logic          load_rsp;
   logic          div_last;
   logic [NW-1:0] nom;
   logic [TW-1:0] now_m;
   logic [TW-1:0] maxc_m;
   logic [34:0]   coarse_prod;
   logic [32:0]   medium_prod;
   logic [36:0]   pct_prod;
   logic [16:0]   limit;
   logic [RW-1:0] rate_in_use;
   logic signed [AW-1:0] nom_s, hi_s, lo_s, r0_s, r1_s, rclamp_s;
   logic [RW:0]   trial;
   logic [RW:0]   trial_sub;
   logic          fits;

   assign nom    = (ticks_per_ms_ff == '0) ? NW'(1) : ticks_per_ms_ff;
   assign now_m  = item_ff.counter_now & CNT_MASK;
   assign maxc_m = counter_max_ff & CNT_MASK;

   assign coarse_prod = {18'b0, nom[19:3]} * {17'b0, artt_pkg::COARSE_RECIP};
   assign medium_prod = {17'b0, nom[19:4]} * {16'b0, artt_pkg::MEDIUM_RECIP};
   assign pct_prod    = {19'b0, nom[19:2]} * {18'b0, artt_pkg::LIMIT_RECIP};
   assign limit       = {pct_ff, 3'b000} + {2'b00, pct_ff, 1'b0};

   assign rate_in_use = (rate_ff == '0) ? {1'b0, nom} : rate_ff;

   // rate adjust: step in signed arithmetic, then clamp to nominal +/- limit
   assign nom_s = signed'({{(AW-NW){1'b0}}, nom});
   assign hi_s  = nom_s + signed'({{(AW-17){1'b0}}, limit});
   assign lo_s  = nom_s - signed'({{(AW-17){1'b0}}, limit});
   assign r0_s  = signed'({{(AW-RW){1'b0}}, rate_in_use});

   always_comb begin
      case (item_ff.adjust_code)
         artt_pkg::ADJ_COARSE_INC: r1_s = r0_s + signed'({{(AW-13){1'b0}}, coarse_ff});
         artt_pkg::ADJ_COARSE_DEC: r1_s = r0_s - signed'({{(AW-13){1'b0}}, coarse_ff});
         artt_pkg::ADJ_MEDIUM_INC: r1_s = r0_s + signed'({{(AW-10){1'b0}}, medium_ff});
         artt_pkg::ADJ_MEDIUM_DEC: r1_s = r0_s - signed'({{(AW-10){1'b0}}, medium_ff});
         artt_pkg::ADJ_FINE_INC:   r1_s = r0_s + AW'(1);
         artt_pkg::ADJ_FINE_DEC:   r1_s = r0_s - AW'(1);
         default:                  r1_s = r0_s;
      endcase
      rclamp_s = r1_s;
      if (rclamp_s > hi_s) begin
         rclamp_s = hi_s;
      end
      if (rclamp_s < lo_s) begin
         rclamp_s = lo_s;
      end
   end

   // one restoring division step per cycle
   assign trial     = {rem_ff, div_ff[DW-1]};
   assign fits      = trial >= {1'b0, divisor_ff};
   assign trial_sub = trial - {1'b0, divisor_ff};
   assign div_last  = div_cnt_ff == CW'(DW - 1);

   assign req_stall  = state_ff != artt_pkg::ST_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign load_rsp   = (state_ff == artt_pkg::ST_RESULT) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= artt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         artt_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = artt_pkg::ST_EXEC;
            end
         end
         artt_pkg::ST_EXEC: begin
            case (item_ff.op)
               artt_pkg::OP_POWER_ON:   state_in = artt_pkg::ST_DIV;
               artt_pkg::OP_TIMER_READ: state_in = primed_ff ? artt_pkg::ST_DELTA
                                                             : artt_pkg::ST_DIV;
               default:                 state_in = artt_pkg::ST_RESULT;
            endcase
         end
         artt_pkg::ST_DELTA:    state_in = artt_pkg::ST_ADD_LEFT;
         artt_pkg::ST_ADD_LEFT: state_in = artt_pkg::ST_DIV;
         artt_pkg::ST_DIV: begin
            if (div_last) begin
               state_in = artt_pkg::ST_UPDATE;
            end
         end
         artt_pkg::ST_UPDATE: state_in = artt_pkg::ST_RESULT;
         artt_pkg::ST_RESULT: begin
            if (load_rsp) begin
               state_in = artt_pkg::ST_IDLE;
            end
         end
         default: state_in = artt_pkg::ST_IDLE;
      endcase
   end

   // configuration writes and derived step sizes
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_ms_ff <= artt_pkg::TICKS_PER_MS_RST;
         counter_max_ff  <= artt_pkg::COUNTER_MAX_RST;
      end else if (csr_we) begin
         case (csr_index)
            artt_pkg::CSR_TICKS_PER_MS: ticks_per_ms_ff <= csr_wdata[NW-1:0];
            artt_pkg::CSR_COUNTER_MAX:  counter_max_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      coarse_ff <= coarse_prod[34:22];
      medium_ff <= medium_prod[32:23];
      pct_ff    <= pct_prod[36:23];
   end

   // architectural timer state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_counter_ff <= '0;
         primed_ff       <= 1'b0;
         timer_value_ff  <= '0;
         leftover_ff     <= '0;
         rate_ff         <= '0;
         was_reset_ff    <= 1'b0;
         was_stopped_ff  <= 1'b0;
      end else begin
         case (state_ff)
            artt_pkg::ST_EXEC: begin
               case (item_ff.op)
                  artt_pkg::OP_POWER_ON: begin
                     last_counter_ff <= now_m;
                     primed_ff       <= 1'b1;
                     rate_ff         <= {1'b0, nom};
                     was_reset_ff    <= 1'b1;
                     was_stopped_ff  <= 1'b1;
                  end
                  artt_pkg::OP_TIMER_READ: begin
                     last_counter_ff <= now_m;
                     primed_ff       <= 1'b1;
                     if (!primed_ff && rate_ff == '0) begin
                        rate_ff <= {1'b0, nom};
                     end
                  end
                  artt_pkg::OP_ADJUST:     rate_ff        <= rclamp_s[RW-1:0];
                  artt_pkg::OP_READ_RESET: was_reset_ff   <= 1'b0;
                  artt_pkg::OP_READ_STOP:  was_stopped_ff <= 1'b0;
                  default: ;
               endcase
            end
            artt_pkg::ST_UPDATE: begin
               // seeding replaces the timer, a read adds the elapsed milliseconds
               timer_value_ff <= seed_ff ? div_ff[TW-1:0] : timer_value_ff + div_ff[TW-1:0];
               leftover_ff    <= rem_ff;
            end
            default: ;
         endcase
      end
   end

   // item capture, delta preparation and bit-serial divider
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_data;
      end
      case (state_ff)
         artt_pkg::ST_EXEC: begin
            rem_ff      <= '0;
            div_cnt_ff  <= '0;
            case (item_ff.op)
               artt_pkg::OP_POWER_ON: begin
                  div_ff      <= {1'b0, now_m};
                  divisor_ff  <= {1'b0, nom};
                  seed_ff     <= 1'b1;
                  res_flag_ff <= 1'b0;
               end
               artt_pkg::OP_TIMER_READ: begin
                  res_flag_ff <= 1'b0;
                  if (primed_ff) begin
                     div_ff     <= {1'b0, now_m - last_counter_ff};
                     wrap_ff    <= now_m < last_counter_ff;
                     divisor_ff <= rate_in_use;
                     seed_ff    <= 1'b0;
                  end else begin
                     div_ff     <= {1'b0, now_m};
                     divisor_ff <= {1'b0, nom};
                     seed_ff    <= 1'b1;
                  end
               end
               artt_pkg::OP_READ_RESET: res_flag_ff <= was_reset_ff;
               artt_pkg::OP_READ_STOP:  res_flag_ff <= was_stopped_ff;
               default:                 res_flag_ff <= 1'b0;
            endcase
         end
         artt_pkg::ST_DELTA: begin
            // on wrap add counter_max + 1, modulo 2^64
            div_ff <= {1'b0, div_ff[TW-1:0] + (wrap_ff ? maxc_m : '0) + {{(TW-1){1'b0}}, wrap_ff}};
         end
         artt_pkg::ST_ADD_LEFT: begin
            div_ff <= div_ff + {{(DW-RW){1'b0}}, leftover_ff};
         end
         artt_pkg::ST_DIV: begin
            div_ff     <= {div_ff[DW-2:0], fits};
            rem_ff     <= fits ? trial_sub[RW-1:0] : trial[RW-1:0];
            div_cnt_ff <= div_cnt_ff + CW'(1);
         end
         default: ;
      endcase
   end

   // output register: hold the beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff.timer_ms <= timer_value_ff;
         rsp_data_ff.flag     <= res_flag_ff;
      end
   end

endmodule
